[rtl/utf8d_pkg.sv]
`default_nettype none

package utf8d_pkg;

  // Input request: one stream byte or an end-of-stream flush
  typedef struct packed {
    logic [7:0] in_byte;
    logic       flush;
  } in_req_t;

  // One decoded result
  typedef struct packed {
    logic [21:0] code_point;
    logic        incomplete;
    logic        last_of_run;
  } out_res_t;

  // Results produced by one request (zero, one or two)
  typedef struct packed {
    logic [1:0] count;
    out_res_t   res0;
    out_res_t   res1;
  } dec_push_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

`default_nettype wire

[rtl/utf8d_core.sv]
`default_nettype none

module utf8d_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  utf8d_pkg::in_req_t   req,
  output utf8d_pkg::dec_push_t push
);

  logic [21:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;

  logic [7:0]  b;
  logic        is_cont;
  logic [1:0]  extra;
  logic [6:0]  lead_mask;
  logic [21:0] lead_val;
  logic [21:0] acc_shift;

  assign b       = req.in_byte;
  assign is_cont = (b[7:6] == utf8d_pkg::CONT_TAG);

  // Count leading ones below the top bit, capped at three
  always_comb begin
    priority if (!b[6]) begin
      extra = 2'd0;
    end else if (!b[5]) begin
      extra = 2'd1;
    end else if (!b[4]) begin
      extra = 2'd2;
    end else begin
      extra = 2'd3;
    end
  end

  assign lead_mask = 7'h7f >> extra;
  assign lead_val  = {15'd0, b[6:0] & lead_mask};
  assign acc_shift = {acc_r[15:0], b[5:0]};

  // Decode one request into results and the next state
  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    push    = '0;
    if (req.flush) begin
      // Drain a pending partial value
      if (rem_r != 2'd0) begin
        push.count           = 2'd1;
        push.res0.code_point = acc_r;
        push.res0.incomplete = 1'b1;
        acc_nxt              = '0;
        rem_nxt              = 2'd0;
      end
    end else if ((rem_r != 2'd0) && is_cont) begin
      // Shift in a continuation byte
      acc_nxt = acc_shift;
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        push.count           = 2'd1;
        push.res0.code_point = acc_shift;
        acc_nxt              = '0;
      end
    end else begin
      // Emit a cut-off sequence first, then take the byte as a lead
      if (rem_r != 2'd0) begin
        push.count           = 2'd1;
        push.res0.code_point = acc_r;
        push.res0.incomplete = 1'b1;
        acc_nxt              = '0;
        rem_nxt              = 2'd0;
      end
      if (!b[7] || (extra == 2'd0)) begin
        if (rem_r != 2'd0) begin
          push.count           = 2'd2;
          push.res1.code_point = b[7] ? lead_val : {14'd0, b};
        end else begin
          push.count           = 2'd1;
          push.res0.code_point = b[7] ? lead_val : {14'd0, b};
        end
      end else begin
        acc_nxt = lead_val;
        rem_nxt = extra;
      end
    end
    // Mark the final result of this request
    if (push.count == 2'd1) begin
      push.res0.last_of_run = 1'b1;
    end else if (push.count == 2'd2) begin
      push.res1.last_of_run = 1'b1;
    end
  end

  // Advance the decoder state on each consumed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 2'd0;
    end else if (fire) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/utf8d_res_queue.sv]
`default_nettype none

module utf8d_res_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_en,
  input  utf8d_pkg::dec_push_t push,
  output logic                 room_two,
  output logic                 out_valid,
  input  wire                  out_ready,
  output utf8d_pkg::out_res_t  out_data
);

  utf8d_pkg::out_res_t            slot_r [utf8d_pkg::QDEPTH];
  logic [utf8d_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [utf8d_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [utf8d_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]                     n_push;
  logic                           pop;

  assign n_push    = push_en ? push.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign room_two  = (cnt_r <= utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + utf8d_pkg::QPTR_W'(n_push);
  assign cnt_nxt    = cnt_r + utf8d_pkg::QCNT_W'(n_push) - utf8d_pkg::QCNT_W'(pop);

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slot_r[wr_ptr_r] <= push.res0;
    end
    if (n_push == 2'd2) begin
      slot_r[wr_ptr_r + utf8d_pkg::QPTR_W'(1)] <= push.res1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + utf8d_pkg::QPTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_stream_decoder_unit.sv]
`default_nettype none

// UTF-8 stream decoder. Each input request carries one stream byte (or a
// flush) and yields zero, one or two code point results. A request is held
// in an input register, decoded by shallow mask and shift logic against the
// accumulator state, and its results are written into a four-entry result
// queue. One request is accepted per cycle whenever the queue has room for
// two results; the first result passes through the input register and then
// the result queue. A request that cuts off a pending sequence with a byte
// that is no multi-byte lead produces two results, which leave the queue in order.
module utf8_stream_decoder_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  utf8d_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output utf8d_pkg::out_res_t out_data
);

  utf8d_pkg::in_req_t   req_r;
  logic                 req_vld_r;
  logic                 room_two;
  logic                 fire;
  utf8d_pkg::dec_push_t push;

  assign fire     = req_vld_r && room_two;
  assign in_ready = !req_vld_r || room_two;

  // Hold the incoming request until the decoder consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
  end

  utf8d_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req_r),
    .push  (push)
  );

  utf8d_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[sim/utf8_stream_decoder_unit_test.sv]
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_test;

  // Random stream shapes
  typedef enum int {
    SEQ_ASCII,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR,
    SEQ_BROKEN,
    SEQ_NOISE,
    SEQ_FLUSH
  } seq_kind_t;

  localparam int unsigned STREAM_ITEMS = 1600;
  localparam int unsigned IDLE_PCT     = 35;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Decoder state mirror and the code points still owed by the block
  class decode_scoreboard;
    logic [21:0]         acc;
    logic [1:0]          left;
    utf8d_pkg::out_res_t pending_points[$];

    function new();
      acc  = '0;
      left = '0;
    endfunction

    function utf8d_pkg::out_res_t make_point(logic [21:0] cp, logic inc);
      utf8d_pkg::out_res_t r;
      r.code_point  = cp;
      r.incomplete  = inc;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    // Advance the mirrored state by one accepted request and queue its results
    function void decode_request(utf8d_pkg::in_req_t req);
      utf8d_pkg::out_res_t batch[$];
      logic [7:0]          b;
      logic [6:0]          mask;
      int unsigned         ones;
      bit                  take_lead;
      b = req.in_byte;
      take_lead = 1'b1;
      if (req.flush) begin
        if (left != 0) begin
          batch.push_back(make_point(acc, 1'b1));
          acc  = '0;
          left = '0;
        end
      end else begin
        if (left != 0) begin
          if (b[7:6] == utf8d_pkg::CONT_TAG) begin
            acc  = {acc[15:0], b[5:0]};
            left = left - 2'd1;
            if (left == 0) begin
              batch.push_back(make_point(acc, 1'b0));
              acc = '0;
            end
            take_lead = 1'b0;
          end else begin
            // cut-off sequence: emit the partial value, then treat b as a lead
            batch.push_back(make_point(acc, 1'b1));
            acc  = '0;
            left = '0;
          end
        end
        if (take_lead) begin
          if (!b[7]) begin
            batch.push_back(make_point({14'd0, b}, 1'b0));
          end else begin
            ones = 0;
            mask = 7'h7f;
            while (ones < 3 && b[6 - ones]) begin
              ones++;
              mask = mask >> 1;
            end
            if (ones == 0) begin
              batch.push_back(make_point({15'd0, b[6:0] & mask}, 1'b0));
            end else begin
              acc  = {15'd0, b[6:0] & mask};
              left = ones[1:0];
            end
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
      foreach (batch[i]) pending_points.push_back(batch[i]);
    endfunction

    // Compare one result with the oldest owed code point; empty string when it matches
    function string check_point(utf8d_pkg::out_res_t got);
      utf8d_pkg::out_res_t want;
      string               msg;
      if (pending_points.size() == 0)
        return $sformatf("unexpected result code_point=%06h incomplete=%0b last_of_run=%0b",
                         got.code_point, got.incomplete, got.last_of_run);
      want = pending_points.pop_front();
      msg  = "";
      if (got.code_point !== want.code_point)
        msg = {msg, $sformatf(" code_point %06h/%06h", got.code_point, want.code_point)};
      if (got.incomplete !== want.incomplete)
        msg = {msg, $sformatf(" incomplete %0b/%0b", got.incomplete, want.incomplete)};
      if (got.last_of_run !== want.last_of_run)
        msg = {msg, $sformatf(" last_of_run %0b/%0b", got.last_of_run, want.last_of_run)};
      if (msg != "") msg = {"result field got/want:", msg};
      return msg;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  utf8d_pkg::in_req_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  utf8d_pkg::out_res_t out_data;

  decode_scoreboard    sb = new();
  utf8d_pkg::in_req_t  burst[$];
  int unsigned         gap_pct = IDLE_PCT;
  int unsigned         sent_count = 0;
  int unsigned         mismatch_count = 0;

  utf8_stream_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Offer one request, with random idle cycles ahead of it, and hold until accepted
  task automatic send_request(input utf8d_pkg::in_req_t req);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.decode_request(req);
    sent_count++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    utf8d_pkg::in_req_t req;
    req.in_byte = b;
    req.flush   = 1'b0;
    send_request(req);
  endtask

  task automatic send_flush(input logic [7:0] b);
    utf8d_pkg::in_req_t req;
    req.in_byte = b;
    req.flush   = 1'b1;
    send_request(req);
  endtask

  // Hold the sender off until every owed code point has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_points.size() != 0);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_byte(int n);
    case (n)
      1:       return 8'hc0 | 8'($urandom_range(0, 31));
      2:       return 8'he0 | 8'($urandom_range(0, 15));
      default: return 8'hf0 | 8'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic utf8d_pkg::in_req_t stream_req(logic [7:0] b, logic f);
    utf8d_pkg::in_req_t req;
    req.in_byte = b;
    req.flush   = f;
    return req;
  endfunction

  // Build the next random run of requests, mostly well-formed sequences
  function automatic void build_sequence();
    seq_kind_t  kind;
    int         pick;
    int         n;
    int         k;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 15)      kind = SEQ_ASCII;
    else if (pick < 35) kind = SEQ_TWO;
    else if (pick < 55) kind = SEQ_THREE;
    else if (pick < 75) kind = SEQ_FOUR;
    else if (pick < 85) kind = SEQ_BROKEN;
    else if (pick < 95) kind = SEQ_NOISE;
    else                kind = SEQ_FLUSH;
    burst.delete();
    case (kind)
      SEQ_ASCII: begin
        burst.push_back(stream_req(8'($urandom_range(0, 127)), 1'b0));
      end
      SEQ_TWO, SEQ_THREE, SEQ_FOUR: begin
        n = (kind == SEQ_TWO) ? 1 : (kind == SEQ_THREE) ? 2 : 3;
        burst.push_back(stream_req(lead_byte(n), 1'b0));
        repeat (n) burst.push_back(stream_req(cont_byte(), 1'b0));
      end
      SEQ_BROKEN: begin
        n = $urandom_range(1, 3);
        burst.push_back(stream_req(lead_byte(n), 1'b0));
        k = $urandom_range(0, n - 1);
        repeat (k) burst.push_back(stream_req(cont_byte(), 1'b0));
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) begin
          burst.push_back(stream_req(b, 1'b1));
        end else begin
          // cut the sequence short with anything that is not a continuation
          if (b[7:6] == utf8d_pkg::CONT_TAG) b[6] = 1'b1;
          burst.push_back(stream_req(b, 1'b0));
        end
      end
      SEQ_NOISE: begin
        burst.push_back(stream_req(8'($urandom_range(0, 255)), 1'b0));
      end
      default: begin
        burst.push_back(stream_req(8'($urandom_range(0, 255)), 1'b1));
      end
    endcase
  endfunction

  // Result side: check each accepted result, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        string msg;
        msg = sb.check_point(out_data);
        if (msg != "") report_mismatch(msg);
      end
      out_ready <= ($urandom_range(0, 99) >= gap_pct);
    end
  end

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // plain ASCII extremes, stray continuations
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'hbf);
    // two-, three- and four-byte extremes, widest lenient lead
    send_byte(8'hc0); send_byte(8'h80);
    send_byte(8'hdf); send_byte(8'hbf);
    send_byte(8'hef); send_byte(8'hbf); send_byte(8'hbf);
    send_byte(8'hff); send_byte(8'hbf); send_byte(8'hbf); send_byte(8'hbf);
    // early ASCII ends a sequence: two results from one request
    send_byte(8'he2); send_byte(8'h41);
    // flush with nothing pending, then with a sequence pending
    send_flush(8'h00);
    send_byte(8'hf4); send_flush(8'hff);
    // early lead ends a sequence and starts a new one
    send_byte(8'hc3); send_byte(8'hc3); send_byte(8'ha9);
    send_byte(8'hf8); send_byte(8'hf0);
    send_flush(8'h5a);

    drain_results();

    while (sent_count < STREAM_ITEMS) begin
      // long stretch with both sides always ready
      gap_pct = (sent_count >= 500 && sent_count < 800) ? 0 : IDLE_PCT;
      build_sequence();
      foreach (burst[i]) send_request(burst[i]);
      if (sent_count >= 1100 && sent_count < 1105) drain_results();
    end
    in_valid <= 1'b0;

    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sb.pending_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
